/* hdl/kvt_pkg.sv */
// Package for the key/value table: sizes, codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package kvt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request action codes; code 3 has no member and acts as a no-op.
    typedef enum logic [1:0] {
        ACT_SET    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    // Source of a table write.
    typedef enum logic [1:0] {
        WR_APPEND,
        WR_UPDATE,
        WR_SHIFT
    } wr_sel_t;

    typedef struct packed {
        logic    ready;      // request port open
        logic    rd_ahead;   // read entry idx+1 instead of idx
        logic    idx_inc;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_load;
        status_t res_status;
        logic    res_hit;    // result value comes from the read entry
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] act;
        logic       at_end;     // index reached entry count
        logic       match;      // read key equals request key
        logic       more;       // an entry follows the index
        logic       full;
        logic       out_free;
    } sts_t;

endpackage

/* hdl/kvt_if.sv */
// Handshake channels of the key/value table: request and result.
// Depends on kvt_pkg for field widths.
interface kvt_req_if
    import kvt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;

    modport source (output valid, output action, output key, output value_in, input ready);
    modport sink   (input valid, input action, input key, input value_in, output ready);
endinterface

interface kvt_rsp_if
    import kvt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [VAL_W-1:0] value_out;

    modport source (output valid, output status, output value_out, input ready);
    modport sink   (input valid, input status, input value_out, output ready);
endinterface

/* hdl/key_value_table.sv */
// Top level of the key/value table: controller plus datapath.
// Depends on kvt_pkg, kvt_if, kvt_ctrl and kvt_datapath.
//
// A table of up to CAPACITY (16) key/value pairs kept in insertion order.
// Each request carries an action: set (update a matching key's value, or
// append a new pair), remove (delete the pair and shift later pairs down)
// or query (return the stored value). Action code 3 does nothing and
// answers ok. Each request yields exactly one result with a status of ok,
// not found or full, and value_out carrying the stored value on a
// successful query, zero otherwise. One request is worked on at a time.
// The search reads and compares one entry at a time, from a table with
// one write port and one registered read port; a remove then moves each
// later pair down with a read step and a write step. No clearing pass is
// needed after reset: only entries below the entry count are ever used.
// The result is held in an output register, so a new request is taken
// while the previous result still waits for the sink.
module key_value_table
    import kvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kvt_req_if.sink    req,
    kvt_rsp_if.source  rsp
);

    cmd_t cmd;   // controller -> datapath
    sts_t sts;   // datapath -> controller

    kvt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    kvt_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

/* hdl/kvt_ctrl.sv */
// Controller state machine of the key/value table.
// Depends on kvt_pkg; drives cmd_t to and reads sts_t from kvt_datapath.
module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.at_end || !(sts.act == ACT_SET || sts.act == ACT_REMOVE ||
                                    sts.act == ACT_QUERY))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (!sts.match)
                begin
                    state_next = S_READ;
                end
                else if (sts.act == ACT_REMOVE)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = sts.more ? S_SHIFT_WR : S_DONE;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.wr_sel = WR_UPDATE;
        cmd.res_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            S_READ:
            begin
                case (sts.act) inside
                    ACT_SET:
                    begin
                        if (sts.at_end)
                        begin
                            cmd.res_load = 1'b1;
                            if (sts.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_sel  = WR_APPEND;
                                cmd.cnt_inc = 1'b1;
                            end
                        end
                    end
                    ACT_REMOVE, ACT_QUERY:
                    begin
                        if (sts.at_end)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                    end
                endcase
            end
            S_CMP:
            begin
                if (!sts.match)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else if (sts.act == ACT_SET)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_UPDATE;
                    cmd.res_load = 1'b1;
                end
                else if (sts.act == ACT_QUERY)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_hit  = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_ahead = 1'b1;
                if (!sts.more)
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.res_load = 1'b1;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_inc = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/kvt_datapath.sv */
// Datapath of the key/value table: key and value memories, search index,
// entry count, request latch, result and output registers. Depends on kvt_pkg, kvt_if.
module kvt_datapath
    import kvt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    kvt_req_if.sink      req,
    kvt_rsp_if.source    rsp,
    input  cmd_t         cmd,
    output sts_t         sts
);

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [VAL_W-1:0] val_mem [CAPACITY];

    logic [1:0]       req_act_reg;
    logic [KEY_W-1:0] req_key_reg;
    logic [VAL_W-1:0] req_val_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_plus1;

    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_val_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_val;

    status_t          res_status_reg;
    logic [VAL_W-1:0] res_value_reg;

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [VAL_W-1:0] out_value_reg;

    logic             take;

    assign req.ready = cmd.ready;
    assign take      = req.valid && cmd.ready;
    assign idx_plus1 = idx_reg + CNT_W'(1);

    always_comb
    begin
        if (take)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_plus1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_act_reg <= req.action;
            req_key_reg <= req.key;
            req_val_reg <= req.value_in;
        end
    end

    // Table memories: one write port, one registered read port.
    assign rd_addr = cmd.rd_ahead ? idx_plus1[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    always_comb
    begin
        wr_addr = idx_reg[IDX_W-1:0];
        wr_key  = req_key_reg;
        wr_val  = req_val_reg;
        case (cmd.wr_sel)
            WR_APPEND:
            begin
                wr_addr = cnt_reg[IDX_W-1:0];
            end
            WR_SHIFT:
            begin
                wr_key = rd_key_reg;
                wr_val = rd_val_reg;
            end
            default:
            begin
                wr_addr = idx_reg[IDX_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_hit ? rd_val_reg : '0;
        end
    end

    // Output register: holds a result while the next request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.value_out = out_value_reg;

    assign sts.req_valid = req.valid;
    assign sts.act       = req_act_reg;
    assign sts.at_end    = (idx_reg == cnt_reg);
    assign sts.match     = (rd_key_reg == req_key_reg);
    assign sts.more      = (idx_plus1 < cnt_reg);
    assign sts.full      = (cnt_reg == CNT_W'(CAPACITY));
    assign sts.out_free  = !out_valid_reg || rsp.ready;

endmodule

/* verif/tb_key_value_table.sv */
// Self-checking testbench for key_value_table: directed table, then random traffic.
// Depends on kvt_pkg, kvt_req_if/kvt_rsp_if and the key_value_table RTL.
// Every result is checked against a directed row's typed expectation or an in-bench table predictor.
module tb_key_value_table
    import kvt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code 3 has no package member; the block treats it as a no-op.
    localparam logic [1:0] ACT_NOP = 2'd3;

    localparam int POOL_SIZE    = 20;    // a bit more keys than entries, so the table fills
    localparam int PHASE_ITEMS  = 550;
    localparam int HOLD_CYCLES  = 300;   // long sink stall that backs up the request port
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;  // worst-case remove plus margin

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] value_out;
    } kv_result_t;

    // One directed row. count > 1 repeats the row with key and value stepping by one.
    // With fixed set, the typed result is the expectation; otherwise the predictor decides.
    typedef struct {
        logic [1:0]       act;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        int               count;
        bit               fixed;
        status_t          exp_status;
        logic [VAL_W-1:0] exp_value;
    } stim_row_t;

    localparam int N_ROWS = 15;

    logic clk;
    logic rst_n;

    kvt_req_if req_ch ();
    kvt_rsp_if rsp_ch ();

    key_value_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the table, kept in insertion order.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] model_keys [CAPACITY];
    logic [VAL_W-1:0] model_vals [CAPACITY];
    int               model_fill;

    kv_result_t       pending_results [$];   // expected results, oldest first

    int  req_idle_pct;       // chance per cycle that the sender holds valid low
    int  rsp_idle_pct;       // chance per cycle that the receiver holds ready low
    int  error_count;
    int  act_count    [4];
    int  status_count [4];
    int  sender_pauses;
    int  long_holds;         // long receiver stalls asked for so far

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    stim_row_t        directed_rows [N_ROWS];

    // Linear search, lowest index wins; applies one request to the mirror.
    function automatic kv_result_t apply_table_op(input logic [1:0] act,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] value);
        kv_result_t res;
        int         hit;
        res.status    = ST_OK;
        res.value_out = '0;
        hit           = -1;
        for (int i = 0; i < model_fill; i++)
            if (hit < 0 && model_keys[i] == key)
                hit = i;
        case (act)
            ACT_SET:
            begin
                if (hit >= 0)
                    model_vals[hit] = value;
                else if (model_fill < CAPACITY)
                begin
                    model_keys[model_fill] = key;
                    model_vals[model_fill] = value;
                    model_fill++;
                end
                else
                    res.status = ST_FULL;
            end
            ACT_REMOVE:
            begin
                if (hit >= 0)
                begin
                    // close the gap: later pairs move down by one
                    for (int i = hit; i < model_fill - 1; i++)
                    begin
                        model_keys[i] = model_keys[i + 1];
                        model_vals[i] = model_vals[i + 1];
                    end
                    model_fill--;
                end
                else
                    res.status = ST_NOT_FOUND;
            end
            ACT_QUERY:
            begin
                if (hit >= 0)
                    res.value_out = model_vals[hit];
                else
                    res.status = ST_NOT_FOUND;
            end
            default: ;   // no-op: ok, value zero, nothing changes
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset. Reset goes low once and never again.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb_key_value_table NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side. An item is taken at an edge where valid and ready are
    // both high; ready is sampled right after the edge, i.e. its value at
    // the edge, since all block outputs change in the NBA region.
    // ------------------------------------------------------------------
    task automatic issue_request(input logic [1:0] act,
                                 input logic [KEY_W-1:0] key,
                                 input logic [VAL_W-1:0] value,
                                 input bit fixed,
                                 input status_t exp_status,
                                 input logic [VAL_W-1:0] exp_value);
        kv_result_t predicted;
        kv_result_t typed;
        // random gap before the request; valid gets exactly one NBA per step
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.key      <= key;
        req_ch.value_in <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // accepted at this edge: keep the mirror in step with the block
        predicted = apply_table_op(act, key, value);
        act_count[act]++;
        if (fixed)
        begin
            typed.status    = exp_status;
            typed.value_out = exp_value;
            pending_results.push_back(typed);
        end
        else
            pending_results.push_back(predicted);
    endtask

    // Sender pause: drop valid and wait until every result is back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        sender_pauses++;
    endtask

    // Random phase. First half leans toward set so the table fills and hits
    // full; second half leans toward remove so it empties again. Keys come
    // mostly from a small pool so that searches hit.
    task automatic run_random_phase(input int n_items, input int send_pct,
                                    input int recv_pct, input bit with_hold);
        logic [1:0]       act;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        int               r;
        req_idle_pct = send_pct;
        rsp_idle_pct = recv_pct;
        key_pool[0]  = '0;
        key_pool[1]  = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        for (int n = 0; n < n_items; n++)
        begin
            if (with_hold && n == n_items / 4)
            begin
                long_holds++;   // sink stalls while we keep offering
            end
            r = $urandom_range(99);
            if (n < n_items / 2)
                act = (r < 55) ? ACT_SET : (r < 70) ? ACT_REMOVE : (r < 95) ? ACT_QUERY : ACT_NOP;
            else
                act = (r < 25) ? ACT_SET : (r < 65) ? ACT_REMOVE : (r < 95) ? ACT_QUERY : ACT_NOP;
            key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(POOL_SIZE - 1)];
            r = $urandom_range(19);
            value = (r == 0) ? '0 : (r == 1) ? '1 : $urandom();
            issue_request(act, key, value, 1'b0, ST_OK, '0);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, one long stall on request, and the check
    // of every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin : result_side
        kv_result_t exp;
        int         hold_left;
        int         holds_served;
        hold_left    = 0;
        holds_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                status_count[rsp_ch.status]++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d value_out=%h",
                             $realtime, rsp_ch.status, rsp_ch.value_out);
                    error_count++;
                end
                else
                begin
                    exp = pending_results.pop_front();
                    if (rsp_ch.status !== exp.status)
                    begin
                        $display("%0t: status mismatch expected=%0d actual=%0d",
                                 $realtime, exp.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.value_out !== exp.value_out)
                    begin
                        $display("%0t: value_out mismatch expected=%h actual=%h",
                                 $realtime, exp.value_out, rsp_ch.value_out);
                        error_count++;
                    end
                end
            end
            if (long_holds != holds_served)
            begin
                hold_left    = HOLD_CYCLES;
                holds_served = long_holds;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        stim_row_t row;
        req_ch.valid    <= 1'b0;
        req_ch.action   <= ACT_SET;
        req_ch.key      <= '0;
        req_ch.value_in <= '0;
        model_fill   = 0;
        error_count  = 0;
        sender_pauses = 0;
        long_holds   = 0;
        req_idle_pct = 24;
        rsp_idle_pct = 66;
        foreach (act_count[i]) act_count[i] = 0;
        foreach (status_count[i]) status_count[i] = 0;

        // Directed rows. value_in is nonzero on some remove/query/no-op rows to
        // show it is ignored there.
        directed_rows = '{
            // empty table after reset
            '{ACT_QUERY,  32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, ST_NOT_FOUND, 32'h0},
            '{ACT_REMOVE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1, 1'b1, ST_NOT_FOUND, 32'h0},
            '{ACT_NOP,    32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,        32'h0},
            // extreme keys and values
            '{ACT_SET,    32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,        32'h0},
            '{ACT_QUERY,  32'h0000_0000, 32'h1234_5678, 1, 1'b1, ST_OK,        32'hFFFF_FFFF},
            '{ACT_SET,    32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, ST_OK,        32'h0},
            // update in place of an existing key
            '{ACT_SET,    32'h0000_0000, 32'h0000_1002, 1, 1'b1, ST_OK,        32'h0},
            // fill the remaining 14 entries
            '{ACT_SET,    32'h0000_1000, 32'h5000_0000, 14, 1'b1, ST_OK,       32'h0},
            // set of a new key on a full table
            '{ACT_SET,    32'h0000_DEAD, 32'hBEEF_0000, 1, 1'b1, ST_FULL,      32'h0},
            '{ACT_QUERY,  32'h0000_0000, 32'h0,         1, 1'b1, ST_OK,        32'h0000_1002},
            // remove the first entry: every later pair shifts down
            '{ACT_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1'b1, ST_OK,        32'h0},
            '{ACT_SET,    32'h0000_DEAD, 32'hBEEF_0001, 1, 1'b1, ST_OK,        32'h0},
            '{ACT_QUERY,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, ST_OK,        32'h0},
            // remove the last entry, then one from the middle
            '{ACT_REMOVE, 32'h0000_DEAD, 32'h0,         1, 1'b1, ST_OK,        32'h0},
            '{ACT_REMOVE, 32'h0000_1007, 32'h0,         1, 1'b0, ST_OK,        32'h0}
        };

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            for (int k = 0; k < row.count; k++)
                issue_request(row.act, row.key + k, row.value + k,
                              row.fixed, row.exp_status, row.exp_value);
        end
        // one more look behind the middle removal, checked by the predictor
        issue_request(ACT_QUERY, 32'h0000_1008, 32'h0, 1'b0, ST_OK, '0);
        drain_results();

        // Idling schedule: sender 24 / receiver 66, then swapped, then none.
        // The no-idle phase carries the long receiver stall.
        run_random_phase(PHASE_ITEMS, 24, 66, 1'b0);
        run_random_phase(PHASE_ITEMS, 66, 24, 1'b0);
        run_random_phase(PHASE_ITEMS, 0, 0, 1'b1);

        // allow for anything stray still in the pipe
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Requests: set %0d, remove %0d, query %0d, no-op %0d; long stalls %0d, pauses %0d",
                 act_count[ACT_SET], act_count[ACT_REMOVE], act_count[ACT_QUERY],
                 act_count[ACT_NOP], long_holds, sender_pauses);
        $display("Results: ok %0d, not found %0d, full %0d; mismatches %0d",
                 status_count[ST_OK], status_count[ST_NOT_FOUND], status_count[ST_FULL],
                 error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_key_value_table OK");
        else
            $display("tb_key_value_table NOT OK");
        $finish;
    end

endmodule

/* key_value_table.f */
hdl/kvt_pkg.sv
hdl/kvt_if.sv
hdl/kvt_ctrl.sv
hdl/kvt_datapath.sv
hdl/key_value_table.sv
verif/tb_key_value_table.sv
